>>> hdl/tagged_value_stream_decoder_assert.svh
// assertion macros shared by the tagged value stream decoder modules
// depends on nothing; included inside module bodies
`ifndef TAGGED_VALUE_STREAM_DECODER_ASSERT_SVH
`define TAGGED_VALUE_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define TVSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tvsd assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define TVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tvsd assertion failed: next-cycle implication");

`endif

>>> hdl/tvsd_pkg.sv
// types and constants of the tagged value stream decoder
// depends on nothing
package tvsd_pkg;

    // tag bytes
    localparam logic [7:0] TAG_U8  = 8'h88;
    localparam logic [7:0] TAG_U16 = 8'h90;
    localparam logic [7:0] TAG_U32 = 8'hA0;
    localparam logic [7:0] TAG_U64 = 8'hC0;
    localparam logic [7:0] TAG_STR = 8'hA2;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LEN_W   = 32;

    // decoder phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_INT     = 3'd1,
        PH_LENTAG  = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // result kind
    typedef enum logic [2:0] {
        KIND_U8      = 3'd0,
        KIND_U16     = 3'd1,
        KIND_U32     = 3'd2,
        KIND_U64     = 3'd3,
        KIND_STRLEN  = 3'd4,
        KIND_STRBYTE = 3'd5,
        KIND_ERROR   = 3'd6
    } t_kind;

    // one decoded result from the core
    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } t_result;

endpackage

>>> hdl/tvsd_byte_if.sv
// byte stream channel with valid/ready handshake
// depends on nothing
interface tvsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hdl/tvsd_result_if.sv
// decoded result channel with valid/ready handshake
// depends on nothing
interface tvsd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

>>> hdl/tvsd_in_stage.sv
// input register of the decoder: holds one byte until the core takes it
// depends on tvsd_byte_if
module tvsd_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tvsd_byte_if.sink    i_in,
    input  logic         i_can_load,
    output logic         o_valid,
    output logic [7:0]   o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // the register frees up when the core consumes its byte
    assign i_in.ready = !r_valid || i_can_load;
    assign w_take     = i_in.valid && i_in.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

>>> hdl/tvsd_core.sv
// decode state machine: tag hunting, integer and length collection, payload
// depends on tvsd_pkg and tagged_value_stream_decoder_assert.svh
module tvsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output tvsd_pkg::t_result o_res
);
    import tvsd_pkg::*;

    t_phase              r_phase, n_phase;
    t_kind               r_item_kind, n_item_kind;
    logic [3:0]          r_bytes_left, n_bytes_left;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0]    r_payload_left, n_payload_left;

    logic [VALUE_W-1:0]  w_acc_shift;
    logic [3:0]          w_bl_dec;
    logic                w_bl_done;
    logic [LEN_W-1:0]    w_pl_dec;
    logic                w_len_zero;
    t_result             w_res;

    // shared datapath terms
    assign w_acc_shift = {r_acc[VALUE_W-9:0], i_byte};
    assign w_bl_dec    = (r_bytes_left != 4'd0) ? r_bytes_left - 4'd1 : 4'd0;
    assign w_bl_done   = (w_bl_dec == 4'd0);
    assign w_pl_dec    = (r_payload_left != '0) ? r_payload_left - LEN_W'(1) : '0;
    assign w_len_zero  = (w_acc_shift[LEN_W-1:0] == '0);

    // next phase
    always_comb begin
        n_phase = PH_TAG;
        unique case (r_phase)
            PH_INT: begin
                n_phase = w_bl_done ? PH_TAG : PH_INT;
            end
            PH_LEN: begin
                if (!w_bl_done) begin
                    n_phase = PH_LEN;
                end else begin
                    n_phase = w_len_zero ? PH_TAG : PH_PAYLOAD;
                end
            end
            PH_LENTAG: begin
                n_phase = (i_byte == TAG_U32) ? PH_LEN : PH_TAG;
            end
            PH_PAYLOAD: begin
                n_phase = (w_pl_dec == '0) ? PH_TAG : PH_PAYLOAD;
            end
            default: begin
                unique case (i_byte)
                    TAG_U8, TAG_U16, TAG_U32, TAG_U64: n_phase = PH_INT;
                    TAG_STR:                           n_phase = PH_LENTAG;
                    default:                           n_phase = PH_TAG;
                endcase
            end
        endcase
    end

    // next counters and accumulator
    always_comb begin
        n_item_kind    = r_item_kind;
        n_bytes_left   = r_bytes_left;
        n_acc          = r_acc;
        n_payload_left = r_payload_left;
        unique case (r_phase)
            PH_INT: begin
                n_acc        = w_acc_shift;
                n_bytes_left = w_bl_dec;
            end
            PH_LEN: begin
                n_acc        = w_acc_shift;
                n_bytes_left = w_bl_dec;
                if (w_bl_done) begin
                    n_payload_left = w_acc_shift[LEN_W-1:0];
                end
            end
            PH_LENTAG: begin
                if (i_byte == TAG_U32) begin
                    n_bytes_left = 4'd4;
                    n_acc        = '0;
                end
            end
            PH_PAYLOAD: begin
                n_payload_left = w_pl_dec;
            end
            default: begin
                unique case (i_byte)
                    TAG_U8: begin
                        n_item_kind  = KIND_U8;
                        n_bytes_left = 4'd1;
                        n_acc        = '0;
                    end
                    TAG_U16: begin
                        n_item_kind  = KIND_U16;
                        n_bytes_left = 4'd2;
                        n_acc        = '0;
                    end
                    TAG_U32: begin
                        n_item_kind  = KIND_U32;
                        n_bytes_left = 4'd4;
                        n_acc        = '0;
                    end
                    TAG_U64: begin
                        n_item_kind  = KIND_U64;
                        n_bytes_left = 4'd8;
                        n_acc        = '0;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    // result for the current byte
    always_comb begin
        w_res.valid = 1'b0;
        w_res.kind  = KIND_ERROR;
        w_res.value = '0;
        w_res.last  = 1'b1;
        unique case (r_phase)
            PH_INT: begin
                w_res.valid = w_bl_done;
                w_res.kind  = r_item_kind;
                w_res.value = w_acc_shift;
            end
            PH_LEN: begin
                w_res.valid = w_bl_done;
                w_res.kind  = KIND_STRLEN;
                w_res.value = {{(VALUE_W-LEN_W){1'b0}}, w_acc_shift[LEN_W-1:0]};
                w_res.last  = w_len_zero;
            end
            PH_LENTAG: begin
                w_res.valid = (i_byte != TAG_U32);
            end
            PH_PAYLOAD: begin
                w_res.valid = 1'b1;
                w_res.kind  = KIND_STRBYTE;
                w_res.value = {{(VALUE_W-8){1'b0}}, i_byte};
                w_res.last  = (w_pl_dec == '0);
            end
            default: begin
                unique case (i_byte)
                    TAG_U8, TAG_U16, TAG_U32, TAG_U64, TAG_STR: w_res.valid = 1'b0;
                    default:                                    w_res.valid = 1'b1;
                endcase
            end
        endcase
        w_res.valid = w_res.valid && i_fire;
    end

    assign o_res = w_res;

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    // item state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_kind    <= KIND_U8;
            r_bytes_left   <= 4'd0;
            r_acc          <= '0;
            r_payload_left <= '0;
        end else if (i_fire) begin
            r_item_kind    <= n_item_kind;
            r_bytes_left   <= n_bytes_left;
            r_acc          <= n_acc;
            r_payload_left <= n_payload_left;
        end
    end

    `include "tagged_value_stream_decoder_assert.svh"

    // every payload byte transfer yields a string byte result
    `TVSD_ASSERT_IMPL(a_payload_emits, i_clk, i_rst_n, i_fire && (r_phase == PH_PAYLOAD), w_res.valid && (w_res.kind == KIND_STRBYTE))
    // an error result carries value zero and ends the item
    `TVSD_ASSERT_IMPL(a_error_shape, i_clk, i_rst_n, w_res.valid && (w_res.kind == KIND_ERROR), (w_res.value == '0) && w_res.last)
    // a result that does not end its item leaves the core in the payload phase
    `TVSD_ASSERT_NEXT(a_open_string, i_clk, i_rst_n, w_res.valid && !w_res.last, r_phase == PH_PAYLOAD)
    // the byte counter never exceeds one 64-bit integer
    `TVSD_ASSERT_IMPL(a_bytes_range, i_clk, i_rst_n, 1'b1, r_bytes_left <= 4'd8)
endmodule

>>> hdl/tvsd_out_stage.sv
// result register of the decoder, drives the result channel
// depends on tvsd_pkg, tvsd_result_if and tagged_value_stream_decoder_assert.svh
module tvsd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tvsd_pkg::t_result i_res,
    output logic              o_can_load,
    tvsd_result_if.source     o_out
);
    import tvsd_pkg::*;

    logic               r_valid;
    t_kind              r_kind;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    // register may be refilled when empty or being drained this cycle
    assign o_can_load = !r_valid || o_out.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res.valid) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
            r_last  <= i_res.last;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.kind  = r_kind;
    assign o_out.value = r_value;
    assign o_out.last  = r_last;

    `include "tagged_value_stream_decoder_assert.svh"

    // a new result only arrives when there is room for it
    `TVSD_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_res.valid, o_can_load)
    // a loaded result shows up on the channel next cycle
    `TVSD_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_res.valid, r_valid)
    // a stalled result is kept
    `TVSD_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_valid && !o_out.ready, r_valid)
endmodule

>>> hdl/tagged_value_stream_decoder.sv
// tagged value stream decoder: one byte per cycle while o_out is not stalled, two-stage registered pipeline
// path: a byte is taken into the input register, decoded combinationally, and its result is held
//   in the result register that drives o_out
// throughput: one byte per cycle while o_out is not stalled, set by the combinational decode between the two registers
// reset: synchronous active-low i_rst_n empties both registers and returns to tag hunting
module tagged_value_stream_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tvsd_byte_if.sink     i_in,
    tvsd_result_if.source o_out
);
    import tvsd_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_can_load;
    logic       w_fire;
    t_result    w_res;

    // byte leaves the input register when the result register has room
    assign w_fire = w_in_valid && w_can_load;

    tvsd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_load (w_can_load),
        .o_valid    (w_in_valid),
        .o_byte     (w_in_byte)
    );

    tvsd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (w_in_byte),
        .o_res   (w_res)
    );

    tvsd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );
endmodule

>>> bench/tb_top.sv
// testbench for the tagged value stream decoder: byte driver, result monitor,
// a cycle-level decode predictor and the stimulus phases
// depends on tvsd_pkg, tvsd_byte_if, tvsd_result_if and tagged_value_stream_decoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tvsd_pkg::*;

    // one decoded result as the block should produce it
    typedef struct {
        t_kind       kind;
        logic [63:0] value;
        logic        last;
    } t_decoded;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tvsd_byte_if   byte_if ();
    tvsd_result_if res_if ();

    tagged_value_stream_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if)
    );

    // raw bytes waiting for their transfer, decoded results waiting to arrive
    logic [7:0]  stream_bytes[$];
    t_decoded    due_results[$];
    t_decoded    checked_result;

    int unsigned sender_idle_pct  = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned hold_cycles_left = 0;
    int unsigned error_count      = 0;

    // decoder state as the predictor tracks it
    t_phase      dec_phase;
    t_kind       dec_int_kind;
    logic [3:0]  dec_bytes_left;
    logic [63:0] dec_acc;
    logic [31:0] dec_payload_left;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void expect_result(t_kind k, logic [63:0] v, logic l);
        t_decoded r;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        due_results.push_back(r);
    endfunction

    function automatic void open_int(t_kind k, logic [3:0] nbytes);
        dec_int_kind   = k;
        dec_bytes_left = nbytes;
        dec_acc        = '0;
        dec_phase      = PH_INT;
    endfunction

    // advance the decoder by one byte and queue the result it causes, if any
    function automatic void decode_byte(logic [7:0] b);
        case (dec_phase)
            PH_INT, PH_LEN: begin
                dec_acc = {dec_acc[55:0], b};
                if (dec_bytes_left != 0)
                    dec_bytes_left = dec_bytes_left - 1'b1;
                if (dec_bytes_left == 0) begin
                    if (dec_phase == PH_INT) begin
                        dec_phase = PH_TAG;
                        expect_result(dec_int_kind, dec_acc, 1'b1);
                    end else begin
                        dec_payload_left = dec_acc[31:0];
                        if (dec_payload_left == 0) begin
                            dec_phase = PH_TAG;
                            expect_result(KIND_STRLEN, 64'd0, 1'b1);
                        end else begin
                            dec_phase = PH_PAYLOAD;
                            expect_result(KIND_STRLEN, {32'd0, dec_payload_left}, 1'b0);
                        end
                    end
                end
            end
            PH_LENTAG: begin
                if (b != TAG_U32) begin
                    dec_phase = PH_TAG;
                    expect_result(KIND_ERROR, 64'd0, 1'b1);
                end else begin
                    dec_bytes_left = 4'd4;
                    dec_acc        = '0;
                    dec_phase      = PH_LEN;
                end
            end
            PH_PAYLOAD: begin
                if (dec_payload_left != 0)
                    dec_payload_left = dec_payload_left - 1;
                if (dec_payload_left == 0) begin
                    dec_phase = PH_TAG;
                    expect_result(KIND_STRBYTE, {56'd0, b}, 1'b1);
                end else begin
                    expect_result(KIND_STRBYTE, {56'd0, b}, 1'b0);
                end
            end
            default: begin
                // tag hunting, also taken from any unused phase value
                dec_phase = PH_TAG;
                case (b)
                    TAG_U8:  open_int(KIND_U8, 4'd1);
                    TAG_U16: open_int(KIND_U16, 4'd2);
                    TAG_U32: open_int(KIND_U32, 4'd4);
                    TAG_U64: open_int(KIND_U64, 4'd8);
                    TAG_STR: dec_phase = PH_LENTAG;
                    default: expect_result(KIND_ERROR, 64'd0, 1'b1);
                endcase
            end
        endcase
    endfunction

    // stream builders
    function automatic void queue_int(logic [7:0] tag, int nbytes, logic [63:0] v);
        stream_bytes.push_back(tag);
        for (int i = nbytes - 1; i >= 0; i--)
            stream_bytes.push_back(v[i*8 +: 8]);
    endfunction

    function automatic void queue_string(logic [31:0] len, int unsigned npay);
        queue_int(TAG_STR, 0, 64'd0);
        queue_int(TAG_U32, 4, {32'd0, len});
        for (int unsigned i = 0; i < npay; i++)
            stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // mostly well-formed items with random content, some broken ones and noise
    function automatic void queue_random_item();
        int unsigned pick;
        int unsigned sel;
        int unsigned len;
        logic [7:0]  tag;
        logic [63:0] v;
        int          nbytes;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 3);
        case (sel)
            0:       begin tag = TAG_U8;  nbytes = 1; end
            1:       begin tag = TAG_U16; nbytes = 2; end
            2:       begin tag = TAG_U32; nbytes = 4; end
            default: begin tag = TAG_U64; nbytes = 8; end
        endcase
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: ;
        endcase
        if (pick < 55) begin
            queue_int(tag, nbytes, v);
        end else if (pick < 82) begin
            len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            queue_string(len, len);
        end else if (pick < 88) begin
            // string whose length tag is wrong
            stream_bytes.push_back(TAG_STR);
            do
                tag = 8'($urandom_range(0, 255));
            while (tag == TAG_U32);
            stream_bytes.push_back(tag);
        end else if (pick < 93) begin
            // integer cut short, the next item runs into it
            queue_int(tag, $urandom_range(0, nbytes - 1), v);
        end else begin
            stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void queue_random_stream(int unsigned nbytes);
        int unsigned stop_at;
        stop_at = stream_bytes.size() + nbytes;
        while (stream_bytes.size() < stop_at)
            queue_random_item();
    endfunction

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || due_results.size() != 0 || hold_cycles_left != 0)
            @(posedge i_clk);
    endtask

    // byte driver: hold the byte until its transfer, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid   <= 1'b0;
            byte_if.in_byte <= 8'h00;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(byte_if.in_byte);
                void'(stream_bytes.pop_front());
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    byte_if.valid   <= 1'b1;
                    byte_if.in_byte <= stream_bytes[0];
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cycles_left != 0)
            hold_cycles_left <= hold_cycles_left - 1;
    end

    // result monitor: compare each transfer with the oldest expected result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%0h last %0b",
                           res_if.kind, res_if.value, res_if.last);
                    error_count++;
                end else begin
                    checked_result = due_results.pop_front();
                    if (res_if.kind !== checked_result.kind) begin
                        $error("kind: expected %0d, actual %0d",
                               checked_result.kind, res_if.kind);
                        error_count++;
                    end
                    if (res_if.value !== checked_result.value) begin
                        $error("value: expected 0x%0h, actual 0x%0h",
                               checked_result.value, res_if.value);
                        error_count++;
                    end
                    if (res_if.last !== checked_result.last) begin
                        $error("last: expected %0b, actual %0b",
                               checked_result.last, res_if.last);
                        error_count++;
                    end
                end
            end
            res_if.ready <= (hold_cycles_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stimulus phases
    initial begin
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'h00;
        res_if.ready    = 1'b0;
        dec_phase        = PH_TAG;
        dec_int_kind     = KIND_U8;
        dec_bytes_left   = '0;
        dec_acc          = '0;
        dec_payload_left = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each integer width once, three of them at an extreme value, unknown tag,
        // bad length tag, zero-length string
        queue_int(TAG_U8, 1, 64'hFF);
        queue_int(TAG_U16, 2, 64'h0000);
        queue_int(TAG_U32, 4, 64'h8000_0001);
        queue_int(TAG_U64, 8, 64'hFFFF_FFFF_FFFF_FFFF);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(TAG_STR);
        stream_bytes.push_back(8'h00);
        queue_string(32'd0, 0);
        wait_drained();

        // no idling, with a long receiver hold-off so the input backs up
        @(posedge i_clk);
        hold_cycles_left <= 300;
        queue_random_stream(320);
        wait_drained();

        // sender mostly idle
        sender_idle_pct <= 78;
        queue_random_stream(330);
        wait_drained();

        // receiver mostly stalling
        sender_idle_pct <= 0;
        recv_stall_pct  <= 78;
        queue_random_stream(330);
        wait_drained();

        // both idling now and then; finish on a string of the largest length
        sender_idle_pct <= 22;
        recv_stall_pct  <= 22;
        queue_random_stream(330);
        queue_string(32'hFFFF_FFFF, 6);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #2_400_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/tvsd_pkg.sv
hdl/tvsd_byte_if.sv
hdl/tvsd_result_if.sv
hdl/tvsd_in_stage.sv
hdl/tvsd_core.sv
hdl/tvsd_out_stage.sv
hdl/tagged_value_stream_decoder.sv
bench/tb_top.sv
